/* sv/lsa_pkg.sv */
// Shared types, constants and helper functions of the light sensor auto-ranging block.
// Depends on nothing; every other file of the block imports it.
package lsa_pkg;

    localparam int RAW_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int LVL_W      = 17;
    localparam int FRAC_W     = 8;
    localparam int SMP_W      = LVL_W + FRAC_W;
    localparam int PREV_W     = SMP_W + 1;
    localparam int ROUND_W    = 3;
    localparam int IN_W       = 2 * RAW_W;
    localparam int OUT_W      = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef logic [SMP_W-1:0]   level_t;
    typedef logic [1:0]         gain_t;
    typedef logic [2:0]         time_code_t;
    typedef logic [ROUND_W-1:0] round_t;

    localparam gain_t GAIN_LOW = 2'd0;
    localparam gain_t GAIN_MAX = 2'd3;

    localparam time_code_t TIME_100MS = 3'd0;
    localparam time_code_t TIME_200MS = 3'd1;
    localparam time_code_t TIME_400MS = 3'd3;
    localparam time_code_t TIME_600MS = 3'd5;

    localparam round_t ROUND_MAX = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_COMP,
        CFG_IR_SCALE,
        CFG_FULL_SCALE,
        CFG_SAT_LEVEL,
        CFG_DIM_LEVEL,
        CFG_SETTLE,
        CFG_MAX_ROUNDS
    } cfg_index_t;

    localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd32768;
    localparam logic [LVL_W-1:0]   RST_SAT_LEVEL  = 17'd50000;
    localparam logic [LVL_W-1:0]   RST_DIM_LEVEL  = 17'd128;
    localparam logic [LVL_W-1:0]   RST_SETTLE     = 17'd10;
    localparam round_t             RST_MAX_ROUNDS = 3'd6;
    localparam time_code_t         RST_TIME       = TIME_400MS;
    localparam logic [PREV_W-1:0]  RST_PREV       = PREV_W'(-256);
    localparam level_t             LEVEL_ONE      = level_t'(256);

    typedef struct packed {
        logic                temp_comp;
        logic [SCALE_W-1:0]  ir_scale;
        logic [SCALE_W-1:0]  full_scale;
        logic [LVL_W-1:0]    sat_level;
        logic [LVL_W-1:0]    dim_level;
        logic [LVL_W-1:0]    settle_delta;
        round_t              max_rounds;
    } cfg_t;

    typedef struct packed {
        logic   first;
        logic   active;
        logic   sat;
        logic   dim;
        level_t vis;
    } dec_req_t;

    typedef struct packed {
        gain_t      gain;
        time_code_t time_code;
        logic       done;
    } dec_res_t;

    // Shorter integration: 600 -> 400 -> 200 ms, with 200 ms as the floor.
    function automatic time_code_t time_down(input time_code_t t);
        case (t)
            TIME_600MS:             return TIME_400MS;
            TIME_400MS, TIME_200MS: return TIME_200MS;
            default:                return t;
        endcase
    endfunction

    // Longer integration: 200 -> 400 -> 600 ms.
    function automatic time_code_t time_up(input time_code_t t);
        case (t)
            TIME_200MS:             return TIME_400MS;
            TIME_400MS, TIME_600MS: return TIME_600MS;
            default:                return t;
        endcase
    endfunction

endpackage

/* sv/lsa_cell.sv */
// One cell of the boxcar shift line: holds one infrared and one full-spectrum sample.
// Depends on lsa_pkg for the sample type.
module lsa_cell import lsa_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  level_t ir_in,
    input  level_t full_in,
    output level_t ir_out,
    output level_t full_out
);

    level_t ir_reg;
    level_t full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_reg   <= '0;
            full_reg <= '0;
        end else if (shift_en) begin
            ir_reg   <= ir_in;
            full_reg <= full_in;
        end
    end

    assign ir_out   = ir_reg;
    assign full_out = full_reg;

endmodule

/* sv/lsa_ring.sv */
// Boxcar averager: a chain of lsa_cell stages, running totals and a reciprocal divider.
// Depends on lsa_pkg and lsa_cell.
module lsa_ring import lsa_pkg::*; #(
    parameter int RING_DEPTH = 8
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  level_t ir_in,
    input  level_t full_in,
    input  logic   avg_load,
    output level_t ir_avg,
    output level_t full_avg
);

    localparam int LOG_D  = $clog2(RING_DEPTH);
    localparam int TOT_W  = SMP_W + LOG_D;
    localparam int PROD_W = 2 * TOT_W + 1;
    localparam int QSH    = TOT_W + LOG_D;
    // Rounded-up reciprocal; exact floor division for every total below 2**TOT_W.
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << QSH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [TOT_W:0] RCP_M = RCP_FULL[TOT_W:0];

    level_t             ir_tap   [RING_DEPTH+1];
    level_t             full_tap [RING_DEPTH+1];
    logic [TOT_W-1:0]   ir_total_reg;
    logic [TOT_W-1:0]   full_total_reg;
    logic [PROD_W-1:0]  ir_prod;
    logic [PROD_W-1:0]  full_prod;
    level_t             ir_avg_reg;
    level_t             full_avg_reg;

    assign ir_tap[0]   = ir_in;
    assign full_tap[0] = full_in;

    for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
        lsa_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (push),
            .ir_in    (ir_tap[k]),
            .full_in  (full_tap[k]),
            .ir_out   (ir_tap[k+1]),
            .full_out (full_tap[k+1])
        );
    end

    // The sample falling off the end of the chain leaves the total as the new one enters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_total_reg   <= '0;
            full_total_reg <= '0;
        end else if (push) begin
            ir_total_reg   <= ir_total_reg + TOT_W'(ir_in) - TOT_W'(ir_tap[RING_DEPTH]);
            full_total_reg <= full_total_reg + TOT_W'(full_in)
                              - TOT_W'(full_tap[RING_DEPTH]);
        end
    end

    assign ir_prod   = PROD_W'(ir_total_reg) * PROD_W'(RCP_M);
    assign full_prod = PROD_W'(full_total_reg) * PROD_W'(RCP_M);

    always_ff @(posedge aclk) begin
        if (avg_load) begin
            ir_avg_reg   <= ir_prod[QSH +: SMP_W];
            full_avg_reg <= full_prod[QSH +: SMP_W];
        end
    end

    assign ir_avg   = ir_avg_reg;
    assign full_avg = full_avg_reg;

endmodule

/* sv/lsa_ctrl.sv */
// Ranging decision: settle test, gain and integration time steps, round limit.
// Depends on lsa_pkg for the configuration, request and result structs.
module lsa_ctrl import lsa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     fire,
    input  dec_req_t req,
    output dec_res_t res,
    output logic     reading_over
);

    gain_t              gain_reg,    gain_next;
    time_code_t         time_reg,    time_next;
    round_t             rounds_reg,  rounds_next;
    logic               lowered_reg, lowered_next;
    logic               over_reg,    over_next;
    logic [PREV_W-1:0]  prev_reg,    prev_next;
    logic               done_next;
    round_t             rounds_base;
    logic               lowered_base;
    level_t             settle_th;
    logic [PREV_W:0]    up_diff;
    logic [PREV_W:0]    dn_diff;
    logic               settled;

    assign settle_th = {cfg.settle_delta, {FRAC_W{1'b0}}};
    assign up_diff   = {2'b00, req.vis} - {prev_reg[PREV_W-1], prev_reg};
    assign dn_diff   = {prev_reg[PREV_W-1], prev_reg} - {2'b00, req.vis};
    // Both signs of the difference are formed at once; the non-negative one is tested.
    assign settled   = (!up_diff[PREV_W] && (up_diff[PREV_W-1:0] < {1'b0, settle_th}))
                    || (!dn_diff[PREV_W] && (dn_diff[PREV_W-1:0] < {1'b0, settle_th}));

    always_comb begin
        gain_next    = gain_reg;
        time_next    = time_reg;
        rounds_next  = rounds_reg;
        lowered_next = lowered_reg;
        prev_next    = prev_reg;
        done_next    = 1'b1;
        rounds_base  = req.first ? '0 : rounds_reg;
        lowered_base = req.first ? 1'b0 : lowered_reg;
        if (req.active) begin
            done_next    = 1'b0;
            rounds_next  = (rounds_base == ROUND_MAX) ? ROUND_MAX : rounds_base + 1'b1;
            lowered_next = lowered_base;
            if (settled) begin
                done_next = 1'b1;
            end else begin
                prev_next = {1'b0, req.vis};
                if (req.sat) begin
                    if (gain_reg != GAIN_LOW) begin
                        gain_next    = gain_reg - 1'b1;
                        lowered_next = 1'b1;
                    end else if (time_reg != TIME_100MS) begin
                        time_next    = time_down(time_reg);
                        lowered_next = 1'b1;
                    end else begin
                        done_next = 1'b1;
                    end
                end else if (req.dim) begin
                    // Once sensitivity came down in this reading it is not raised again.
                    if (!lowered_base) begin
                        if (gain_reg != GAIN_MAX) begin
                            gain_next = gain_reg + 1'b1;
                        end else if (time_reg != TIME_600MS) begin
                            time_next = time_up(time_reg);
                        end else begin
                            done_next = 1'b1;
                        end
                    end
                end else begin
                    done_next = 1'b1;
                end
            end
            if (rounds_next >= cfg.max_rounds) begin
                done_next = 1'b1;
            end
        end
        over_next = req.active ? done_next : over_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_LOW;
            time_reg    <= RST_TIME;
            rounds_reg  <= '0;
            lowered_reg <= 1'b0;
            over_reg    <= 1'b1;
            prev_reg    <= RST_PREV;
        end else if (fire) begin
            gain_reg    <= gain_next;
            time_reg    <= time_next;
            rounds_reg  <= rounds_next;
            lowered_reg <= lowered_next;
            over_reg    <= over_next;
            prev_reg    <= prev_next;
        end
    end

    assign res.gain      = gain_next;
    assign res.time_code = time_next;
    assign res.done      = done_next;
    assign reading_over  = over_reg;

    a_time_reachable: assert property (@(posedge aclk) disable iff (!aresetn)
        (time_reg == TIME_200MS) || (time_reg == TIME_400MS) || (time_reg == TIME_600MS))
        else $error("integration time left the 200/400/600 ms set");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable({gain_reg, time_reg, over_reg, prev_reg}))
        else $error("ranging state changed without a decision");

    a_over_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (over_reg && !(fire && req.first)) |=> over_reg)
        else $error("finished reading reopened without a first sample");

endmodule

/* sv/light_sensor_autorange.sv */
// Top level of the light sensor auto-ranging block: ports, scaling, pipeline and result register.
// Depends on lsa_pkg, lsa_ring (with lsa_cell) and lsa_ctrl.
//
// Usage. Each input item is one sensor conversion: s_tdata carries the raw infrared and
// full-spectrum counts, s_tuser flags the first sample of a new reading. Each item gives
// exactly one result item on the m_ side: the gain and integration time codes to use next,
// the boxcar averages and the visible level, with m_tlast high once the reading is finished.
// Samples that arrive after a reading finished, without the first flag, are not averaged;
// they return the current settings with m_tlast high.
// Items pass p1 to p4 and the output register before m_tvalid. An item with s_tuser set
// can follow in the next cycle. One that continues a reading waits in p1 until the item
// before it is decided, so inside a reading a new sample is taken only once the last is
// decided: the finished flag set in p4 decides if the next sample enters the averaging
// chain. The user writes configuration through the cfg_ channel while no item is in flight;
// the block does not enforce it. cfg_ready is always high and a write to index 7 is dropped.
// Reset (aresetn low at a clock edge) clears the averaging chain and the totals, restores
// the register defaults, low gain and 400 ms, and marks the reading finished.
// When the receiver stalls, the result waits in the output register and the pipeline keeps
// taking items until its four stages are full; then s_tready goes low.
module light_sensor_autorange import lsa_pkg::*; #(
    parameter int RING_DEPTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,    // raw_ir [15:0], raw_full [31:16]
    input  logic                  s_tuser,    // first_of_reading [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,    // gain_code [1:0], time_code [4:2],
                                              // ir_average [29:5], full_average [54:30],
                                              // visible_level [79:55]
    output logic                  m_tlast,    // done_res
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic [RAW_W-1:0]   raw_ir;
    logic [RAW_W-1:0]   raw_full;
    logic [31:0]        ir_prod;
    logic [31:0]        full_prod;
    logic [31:0]        ir_round;
    logic [31:0]        full_round;
    level_t             ir_smp;
    level_t             full_smp;

    logic               p1_valid_reg, p1_first_reg;
    level_t             p1_ir_reg, p1_full_reg;
    logic               p2_valid_reg, p2_first_reg, p2_act_reg;
    logic               p3_valid_reg, p3_first_reg, p3_act_reg;
    logic               p4_valid_reg, p4_first_reg, p4_act_reg;
    logic               p4_sat_reg, p4_dim_reg;
    level_t             p4_ir_reg, p4_full_reg, p4_vis_reg;
    logic               out_valid_reg, out_last_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               out_free, p4_move, p4_free, p3_move, p3_free;
    logic               p2_move, p2_free, p1_move, p1_free;
    logic               hazard_clear, p1_act, push;
    logic               reading_over;
    level_t             ir_avg, full_avg, vis;
    level_t             sat_th, dim_th;
    logic               sat_hit, dim_hit;
    dec_req_t           req;
    dec_res_t           res;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_comp    <= 1'b0;
            cfg_reg.ir_scale     <= RST_SCALE;
            cfg_reg.full_scale   <= RST_SCALE;
            cfg_reg.sat_level    <= RST_SAT_LEVEL;
            cfg_reg.dim_level    <= RST_DIM_LEVEL;
            cfg_reg.settle_delta <= RST_SETTLE;
            cfg_reg.max_rounds   <= RST_MAX_ROUNDS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TEMP_COMP:  cfg_reg.temp_comp    <= cfg_data[0];
                CFG_IR_SCALE:   cfg_reg.ir_scale     <= cfg_data[SCALE_W-1:0];
                CFG_FULL_SCALE: cfg_reg.full_scale   <= cfg_data[SCALE_W-1:0];
                CFG_SAT_LEVEL:  cfg_reg.sat_level    <= cfg_data[LVL_W-1:0];
                CFG_DIM_LEVEL:  cfg_reg.dim_level    <= cfg_data[LVL_W-1:0];
                CFG_SETTLE:     cfg_reg.settle_delta <= cfg_data[LVL_W-1:0];
                CFG_MAX_ROUNDS: cfg_reg.max_rounds   <= cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1 input: Q1.15 temperature scaling rounded half up to Q17.8, or a plain shift
    // into Q17.8 when compensation is off.
    assign raw_ir     = s_tdata[RAW_W-1:0];
    assign raw_full   = s_tdata[IN_W-1:RAW_W];
    assign ir_prod    = 32'(raw_ir) * 32'(cfg_reg.ir_scale);
    assign full_prod  = 32'(raw_full) * 32'(cfg_reg.full_scale);
    assign ir_round   = ir_prod + 32'd64;
    assign full_round = full_prod + 32'd64;
    assign ir_smp     = cfg_reg.temp_comp ? ir_round[31:7] : {1'b0, raw_ir, 8'b0};
    assign full_smp   = cfg_reg.temp_comp ? full_round[31:7] : {1'b0, raw_full, 8'b0};

    // Pipeline flow. A stage moves on when the one after it is empty or moving.
    assign out_free = !out_valid_reg || m_tready;
    assign p4_move  = p4_valid_reg && out_free;
    assign p4_free  = !p4_valid_reg || p4_move;
    assign p3_move  = p3_valid_reg && p4_free;
    assign p3_free  = !p3_valid_reg || p3_move;
    assign p2_move  = p2_valid_reg && p3_free;
    assign p2_free  = !p2_valid_reg || p2_move;

    // A sample that continues a reading needs the finished flag of the item before it,
    // so it waits until no earlier item is still undecided. A first sample does not.
    assign hazard_clear = !(p2_valid_reg || p3_valid_reg || p4_valid_reg);
    assign p1_move      = p1_valid_reg && p2_free && (p1_first_reg || hazard_clear);
    assign p1_free      = !p1_valid_reg || p1_move;
    assign s_tready     = p1_free;
    assign p1_act       = p1_first_reg || !reading_over;
    assign push         = p1_move && p1_act;

    lsa_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .ir_in    (p1_ir_reg),
        .full_in  (p1_full_reg),
        .avg_load (p2_move),
        .ir_avg   (ir_avg),
        .full_avg (full_avg)
    );

    // Stage 3 output: visible level and the threshold tests that need no ranging state.
    assign vis     = (full_avg > ir_avg) ? (full_avg - ir_avg) : LEVEL_ONE;
    assign sat_th  = {cfg_reg.sat_level, {FRAC_W{1'b0}}};
    assign dim_th  = {cfg_reg.dim_level, {FRAC_W{1'b0}}};
    assign sat_hit = (full_avg >= sat_th) || (ir_avg >= sat_th);
    assign dim_hit = vis < dim_th;

    assign req.first  = p4_first_reg;
    assign req.active = p4_act_reg;
    assign req.sat    = p4_sat_reg;
    assign req.dim    = p4_dim_reg;
    assign req.vis    = p4_vis_reg;

    lsa_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .fire         (p4_move),
        .req          (req),
        .res          (res),
        .reading_over (reading_over)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p1_free) begin
                p1_valid_reg <= s_tvalid;
            end
            if (p2_free) begin
                p2_valid_reg <= p1_move;
            end
            if (p3_free) begin
                p3_valid_reg <= p2_move;
            end
            if (p4_free) begin
                p4_valid_reg <= p3_move;
            end
            if (out_free) begin
                out_valid_reg <= p4_move;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && p1_free) begin
            p1_first_reg <= s_tuser;
            p1_ir_reg    <= ir_smp;
            p1_full_reg  <= full_smp;
        end
        if (p1_move) begin
            p2_first_reg <= p1_first_reg;
            p2_act_reg   <= p1_act;
        end
        if (p2_move) begin
            p3_first_reg <= p2_first_reg;
            p3_act_reg   <= p2_act_reg;
        end
        if (p3_move) begin
            p4_first_reg <= p3_first_reg;
            p4_act_reg   <= p3_act_reg;
            p4_sat_reg   <= sat_hit;
            p4_dim_reg   <= dim_hit;
            p4_ir_reg    <= ir_avg;
            p4_full_reg  <= full_avg;
            p4_vis_reg   <= vis;
        end
        if (p4_move) begin
            out_data_reg <= {p4_vis_reg, p4_full_reg, p4_ir_reg, res.time_code, res.gain};
            out_last_reg <= res.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_ring_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_valid_reg && !p2_first_reg) |-> !(p3_valid_reg || p4_valid_reg))
        else $error("continuing sample averaged before the previous decision");

    a_avg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (p3_valid_reg && !p3_first_reg) |-> !p4_valid_reg)
        else $error("continuing sample overtook an undecided item");

endmodule
